/* hdl/flow_packet_statistics_update_assert.svh */
// Assertion macros for the flow statistics checker.
`ifndef FLOW_PACKET_STATISTICS_UPDATE_ASSERT_SVH
`define FLOW_PACKET_STATISTICS_UPDATE_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define FPSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flow statistics assertion failed");
// Next-cycle implication, disabled during reset.
`define FPSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flow statistics assertion failed");
`endif

/* hdl/fpsu_pkg.sv */
// Package: constants, types and sequencer states of the flow statistics block.
package fpsu_pkg;
    localparam int DEF_FRAC_BITS  = 8;
    localparam int DEF_LEN_BITS   = 16;
    localparam int DEF_TIME_BITS  = 48;
    localparam int DEF_COUNT_BITS = 32;

    localparam int DIV_W  = 41;  // dividend magnitude
    localparam int ACC_W  = 42;  // signed mean arithmetic
    localparam int DEN_W  = 32;  // divisor width
    localparam int MUL_W  = 32;
    localparam int PAYS_W = 32;  // scaled payload

    localparam logic [39:0] MEAN40_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [23:0] MEAN24_MAX = 24'hFF_FFFF;

    localparam logic [1:0] SEL_LEN = 2'd0;
    localparam logic [1:0] SEL_OFF = 2'd1;
    localparam logic [1:0] SEL_GAP = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_SQ,
        ST_MUL_D2,
        ST_MUL_D4,
        ST_MUL_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SPREAD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [DIV_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quo;
    } t_div_rsp;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction
endpackage

/* hdl/fpsu_if.sv */
// Channel interfaces: packet input and statistics output.
interface fpsu_in_if;
    logic        valid;
    logic        ready;
    logic        first_packet;
    logic [15:0] payload_len;
    logic [15:0] packet_len;
    logic [47:0] packet_time_us;
    logic [47:0] flow_start_us;
    modport source(output valid, first_packet, payload_len, packet_len, packet_time_us,
                   flow_start_us, input ready);
    modport sink(input valid, first_packet, payload_len, packet_len, packet_time_us,
                 flow_start_us, output ready);
endinterface

interface fpsu_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] mean_payload;
    logic [15:0] min_payload;
    logic [15:0] max_payload;
    logic [63:0] square_sum;
    logic [63:0] deviation_sum;
    logic [63:0] fourth_power_sum;
    logic [39:0] mean_offset_time;
    logic [39:0] mean_gap;
    logic [31:0] min_gap;
    logic [31:0] max_gap;
    logic [63:0] gap_spread_sum;
    logic [31:0] switch_count;
    modport source(output valid, mean_payload, min_payload, max_payload, square_sum,
                   deviation_sum, fourth_power_sum, mean_offset_time, mean_gap, min_gap,
                   max_gap, gap_spread_sum, switch_count, input ready);
    modport sink(input valid, mean_payload, min_payload, max_payload, square_sum,
                 deviation_sum, fourth_power_sum, mean_offset_time, mean_gap, min_gap,
                 max_gap, gap_spread_sum, switch_count, output ready);
endinterface

/* hdl/fpsu_div.sv */
// Iterative restoring divider: signed dividend by unsigned count, one bit a cycle.
module fpsu_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpsu_pkg::t_div_req i_req,
    output fpsu_pkg::t_div_rsp o_rsp
);
    import fpsu_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_act;
    logic             r_neg;
    logic [DIV_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_sub;
    logic [ACC_W-1:0] quo_ext;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
        quo_ext = {{(ACC_W-DIV_W){1'b0}}, r_quo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_act <= 1'b1;
            r_cnt <= CNT_W'(DIV_W);
        end else if (r_act && r_cnt == '0) begin
            r_act <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.mag;
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.neg;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_rsp.done = r_act && (r_cnt == '0);
    assign o_rsp.quo  = r_neg ? (~quo_ext + 1'b1) : quo_ext;
endmodule

/* hdl/fpsu_mul.sv */
// Shared 32 by 32 multiplier with a registered product.
module fpsu_mul (
    input  logic                    i_clk,
    input  logic [fpsu_pkg::MUL_W-1:0] i_a,
    input  logic [fpsu_pkg::MUL_W-1:0] i_b,
    output logic [2*fpsu_pkg::MUL_W-1:0] o_p
);
    import fpsu_pkg::*;

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule

/* hdl/flow_packet_statistics_update.sv */
// Top level: per-packet running statistics of one flow, iterative shared divider.
//
//  channel | dir | handshake          | payload
//  i_in    | in  | valid/ready        | first_packet, payload_len, packet_len, times
//  o_out   | out | valid/ready        | means, min/max, saturating sums, switch count
//
// Per packet, from one transfer to the next: a prepare state, the multiplier states
// (square, deviation square, fourth power, accumulate), three divisions (start, 41
// quotient bits, store of the mean), the spread update, the output load and the idle
// state that takes the next transfer. The divider, one bit a cycle, takes most time.
// i_in.ready is high only in the idle state; the load state waits while the previous
// result still sits untaken on o_out, and the input stalls with it.
// Reset is synchronous, active low, and brings all statistics to their reset values.
module flow_packet_statistics_update #(
    parameter int FRAC_BITS  = fpsu_pkg::DEF_FRAC_BITS,
    parameter int LEN_BITS   = fpsu_pkg::DEF_LEN_BITS,
    parameter int TIME_BITS  = fpsu_pkg::DEF_TIME_BITS,
    parameter int COUNT_BITS = fpsu_pkg::DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpsu_in_if.sink     i_in,
    fpsu_out_if.source  o_out
);
    import fpsu_pkg::*;

    localparam logic [15:0] LEN_MASK  = 16'((64'd1 << LEN_BITS) - 64'd1);
    localparam logic [47:0] TIME_MASK = (TIME_BITS >= 48) ? 48'hFFFF_FFFF_FFFF
                                        : 48'((64'd1 << TIME_BITS) - 64'd1);
    localparam logic [39:0] SCALE_LIM = MEAN40_MAX >> FRAC_BITS;

    t_state r_state, n_state;

    // latched packet
    logic [15:0] r_pay;
    logic [15:0] r_plen;
    logic [47:0] r_now;
    logic [47:0] r_start;

    // flow statistics
    logic [COUNT_BITS-1:0] r_count;
    logic [23:0] r_mean_len;
    logic [15:0] r_min_len, r_max_len;
    logic [63:0] r_square, r_deviation, r_fourth;
    logic [47:0] r_last_time;
    logic [39:0] r_off_mean, r_gap_mean;
    logic [31:0] r_gap_min, r_gap_max;
    logic [63:0] r_spread;
    logic [15:0] r_last_len;
    logic [31:0] r_switch;

    // per-packet working values
    logic [PAYS_W-1:0] r_pay_s;
    logic [39:0] r_off_s, r_gap_s;
    logic [15:0] r_d;
    logic [1:0]  r_dsel;

    // output register
    logic        r_out_valid;

    logic        in_acc;
    logic        out_free;
    logic [47:0] gap, off;
    logic [39:0] gap_s, off_s;
    logic [31:0] g32;
    logic [PAYS_W-1:0] pay_s, dev, dsh;
    logic [MUL_W-1:0] mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;
    logic [ACC_W-1:0] div_x, div_acc, diff, mean_new;
    logic [39:0] mean_max, mean_clamped;
    t_div_req div_req;
    t_div_rsp div_rsp;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // gap, offset and payload scaling and the payload deviation from the latched packet
    always_comb begin
        gap   = (r_now > r_last_time) ? r_now - r_last_time : '0;
        off   = (r_now > r_start) ? r_now - r_start : '0;
        gap_s = ((gap > {8'd0, SCALE_LIM}) ? SCALE_LIM : gap[39:0]) << FRAC_BITS;
        off_s = ((off > {8'd0, SCALE_LIM}) ? SCALE_LIM : off[39:0]) << FRAC_BITS;
        g32   = (gap > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : gap[31:0];
        pay_s = {{(PAYS_W-16){1'b0}}, r_pay} << FRAC_BITS;
        dev   = (pay_s >= {8'd0, r_mean_len}) ? pay_s - {8'd0, r_mean_len}
                                               : {8'd0, r_mean_len} - pay_s;
        dsh   = dev >> FRAC_BITS;
    end

    // operand selection for the shared divider and clamping of the new mean
    always_comb begin
        unique case (r_dsel)
            SEL_LEN: begin
                div_x    = ACC_W'(r_pay_s);
                div_acc  = ACC_W'(r_mean_len);
                mean_max = {16'd0, MEAN24_MAX};
            end
            SEL_OFF: begin
                div_x    = ACC_W'(r_off_s);
                div_acc  = ACC_W'(r_off_mean);
                mean_max = MEAN40_MAX;
            end
            default: begin
                div_x    = ACC_W'(r_gap_s);
                div_acc  = ACC_W'(r_gap_mean);
                mean_max = MEAN40_MAX;
            end
        endcase
        diff     = div_x - div_acc;
        mean_new = div_acc + div_rsp.quo;
        if (mean_new[ACC_W-1]) begin
            mean_clamped = '0;
        end else if (mean_new > ACC_W'(mean_max)) begin
            mean_clamped = mean_max;
        end else begin
            mean_clamped = mean_new[39:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (in_acc) n_state = ST_PREP;
            ST_PREP:     n_state = ST_MUL_SQ;
            ST_MUL_SQ:   n_state = ST_MUL_D2;
            ST_MUL_D2:   n_state = ST_MUL_D4;
            ST_MUL_D4:   n_state = ST_MUL_ACC;
            ST_MUL_ACC:  n_state = ST_DIV_GO;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_rsp.done) n_state = (r_dsel == SEL_GAP) ? ST_SPREAD : ST_DIV_GO;
            end
            ST_SPREAD:   n_state = ST_DONE;
            ST_DONE:     if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_in.ready    = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_req.start = 1'b0;
        div_req.neg   = diff[ACC_W-1];
        div_req.mag   = diff[ACC_W-1] ? DIV_W'(~diff + 1'b1) : diff[DIV_W-1:0];
        div_req.den   = DEN_W'(r_count);
        unique case (r_state)
            ST_IDLE:   i_in.ready = 1'b1;
            ST_MUL_SQ: begin
                mul_a = MUL_W'(r_pay);
                mul_b = MUL_W'(r_pay);
            end
            ST_MUL_D2: begin
                mul_a = MUL_W'(r_d);
                mul_b = MUL_W'(r_d);
            end
            ST_MUL_D4: begin
                mul_a = mul_p[MUL_W-1:0];
                mul_b = mul_p[MUL_W-1:0];
            end
            ST_DIV_GO: div_req.start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latch the packet on transfer
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pay   <= i_in.payload_len & LEN_MASK;
            r_plen  <= i_in.packet_len & LEN_MASK;
            r_now   <= i_in.packet_time_us & TIME_MASK;
            r_start <= i_in.flow_start_us & TIME_MASK;
        end
    end

    // working values, set while preparing
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            r_pay_s <= pay_s;
            r_off_s <= off_s;
            r_gap_s <= gap_s;
            r_d     <= (dsh > 32'h0000_FFFF) ? 16'hFFFF : dsh[15:0];
        end
    end

    // statistics; a new flow clears them on the transfer itself, but sets the last time to the packet's time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_in.first_packet)) begin
            r_count     <= '0;
            r_mean_len  <= '0;
            r_min_len   <= 16'hFFFF;
            r_max_len   <= '0;
            r_square    <= '0;
            r_deviation <= '0;
            r_fourth    <= '0;
            r_last_time <= (i_rst_n) ? (i_in.packet_time_us & TIME_MASK) : '0;
            r_off_mean  <= '0;
            r_gap_mean  <= '0;
            r_gap_min   <= 32'hFFFF_FFFF;
            r_gap_max   <= '0;
            r_spread    <= '0;
            r_last_len  <= '0;
            r_switch    <= '0;
            r_dsel      <= SEL_LEN;
        end else begin
            unique case (r_state)
                ST_PREP: begin
                    if (r_count != '1) r_count <= r_count + 1'b1;
                    r_last_time <= r_now;
                    r_deviation <= sat_add64(r_deviation, 64'(dev));
                    if (r_pay < r_min_len) r_min_len <= r_pay;
                    if (r_pay > r_max_len) r_max_len <= r_pay;
                    if (g32 < r_gap_min) r_gap_min <= g32;
                    if (g32 > r_gap_max) r_gap_max <= g32;
                    if (r_last_len != r_plen) begin
                        if (r_switch != 32'hFFFF_FFFF) r_switch <= r_switch + 1'b1;
                        r_last_len <= r_plen;
                    end
                    r_dsel <= SEL_LEN;
                end
                ST_MUL_D2:  r_square <= sat_add64(r_square, mul_p);
                ST_MUL_ACC: r_fourth <= sat_add64(r_fourth, mul_p);
                ST_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        unique case (r_dsel)
                            SEL_LEN: r_mean_len <= mean_clamped[23:0];
                            SEL_OFF: r_off_mean <= mean_clamped;
                            default: r_gap_mean <= mean_clamped;
                        endcase
                        r_dsel <= r_dsel + 1'b1;
                    end
                end
                ST_SPREAD: begin
                    r_spread <= sat_add64(r_spread, 64'((r_gap_mean >= r_gap_s)
                                ? r_gap_mean - r_gap_s : r_gap_s - r_gap_mean));
                end
                default: ;
            endcase
        end
    end

    // output register: load when free, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            o_out.mean_payload     <= r_mean_len;
            o_out.min_payload      <= r_min_len;
            o_out.max_payload      <= r_max_len;
            o_out.square_sum       <= r_square;
            o_out.deviation_sum    <= r_deviation;
            o_out.fourth_power_sum <= r_fourth;
            o_out.mean_offset_time <= r_off_mean;
            o_out.mean_gap         <= r_gap_mean;
            o_out.min_gap          <= r_gap_min;
            o_out.max_gap          <= r_gap_max;
            o_out.gap_spread_sum   <= r_spread;
            o_out.switch_count     <= r_switch;
        end
    end

    assign o_out.valid = r_out_valid;

    fpsu_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    fpsu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );
endmodule

/* hdl/fpsu_checker.sv */
// Port checker for the flow statistics block, bound to the top level.
`include "flow_packet_statistics_update_assert.svh"
module fpsu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [23:0] i_mean_payload,
    input logic [15:0] i_min_payload,
    input logic [15:0] i_max_payload,
    input logic [31:0] i_min_gap,
    input logic [31:0] i_max_gap
);
    `FPSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_mean_payload) && $stable(i_min_payload))
    `FPSU_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `FPSU_ASSERT_NOW(a_payload_order, i_clk, i_rst_n, i_out_valid, i_min_payload <= i_max_payload)
    `FPSU_ASSERT_NOW(a_gap_order, i_clk, i_rst_n, i_out_valid, i_min_gap <= i_max_gap)
endmodule

bind flow_packet_statistics_update fpsu_checker u_fpsu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_mean_payload (o_out.mean_payload),
    .i_min_payload  (o_out.min_payload),
    .i_max_payload  (o_out.max_payload),
    .i_min_gap      (o_out.min_gap),
    .i_max_gap      (o_out.max_gap)
);
